[rtl/core/qpu_pkg.sv]
// ----------------------------------------------------------------------------
// qpu_pkg: shared types and constants of the quaternion product unit
// Word format, operation codes and the sign pattern of the Hamilton product.
// ----------------------------------------------------------------------------
package qpu_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned PROD_BITS = 2 * WORD_BITS;
  // four partial products summed need two guard bits
  localparam int unsigned ACC_BITS  = PROD_BITS + 2;
  localparam int unsigned SH_BITS   = ACC_BITS - FRAC_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;
  typedef logic signed [SH_BITS-1:0]   sh_t;
  typedef word_t quat_t [4];

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

  typedef enum logic [1:0] {
    CMD_PRODUCT  = 2'd0,
    CMD_CONJ     = 2'd1,
    CMD_SANDWICH = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  // component k of p*q takes term n from p[n] * q[k ^ n]; this gives its sign
  function automatic logic hp_neg(input logic [1:0] k, input logic [1:0] n);
    logic neg;
    unique case ({k, n})
      4'b0001, 4'b0010, 4'b0011,
      4'b0111, 4'b1001, 4'b1110: neg = 1'b1;
      default:                   neg = 1'b0;
    endcase
    return neg;
  endfunction

endpackage

[rtl/core/quaternion_product_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_product_unit: fixed-point quaternion product, conjugate, rotate
// Signed Q4.28 components. Product a*b, conjugate of a, or the vector part of
// a*(0,v)*b, with truncation toward minus infinity and saturation.
//
//   channel  handshake          payload
//   input    valid_i / stall_o  cmd_i, a_*_i, b_*_i, v_*_i
//   output   valid_o / stall_i  r_w_o, r_x_o, r_y_o, r_z_o, saturated_o
//
// One item per cycle while stall_o is low: two product units of three stages
// each (multiply, sum, clip) in series, then the output register.
// Reset clears the stage valid bits only; no warm-up is needed.
// Each stage moves forward when it is empty or the next one moves, so bubbles
// close up while the output is stalled; stall_o rises only when all are full.
// ----------------------------------------------------------------------------
module quaternion_product_unit
  import qpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  cmd_i,
  input  word_t       a_w_i,
  input  word_t       a_x_i,
  input  word_t       a_y_i,
  input  word_t       a_z_i,
  input  word_t       b_w_i,
  input  word_t       b_x_i,
  input  word_t       b_y_i,
  input  word_t       b_z_i,
  input  word_t       v_x_i,
  input  word_t       v_y_i,
  input  word_t       v_z_i,
  output logic        valid_o,
  input  logic        stall_i,
  output word_t       r_w_o,
  output word_t       r_x_o,
  output word_t       r_y_o,
  output word_t       r_z_o,
  output logic        saturated_o
);

  localparam int unsigned NSTG = 7;

  logic [NSTG:1]   vld_q;
  logic [NSTG+1:1] go;

  // stages 1 to 3: side data beside the inner product
  cmd_e  cmd13_q [1:3];
  quat_t a13_q   [1:3];
  quat_t b13_q   [1:3];

  // stages 4 to 6: side data beside the outer product
  cmd_e  cmd46_q  [4:6];
  quat_t conj46_q [4:6];
  logic  csat46_q [4:6];
  logic  tsat46_q [4:6];

  quat_t a_in, b_in, v_in;
  quat_t t_r, u_r;
  logic [3:0] t_clip, u_clip;
  quat_t q2_in;
  quat_t conj_d;
  logic  csat_d;

  quat_t r_d, r_q;
  logic  sat_d, sat_q;

  assign a_in = '{a_w_i, a_x_i, a_y_i, a_z_i};
  assign b_in = '{b_w_i, b_x_i, b_y_i, b_z_i};
  assign v_in = '{word_t'(0), v_x_i, v_y_i, v_z_i};

  // stage advance chain, from the output back to the input
  always_comb begin
    go[NSTG+1] = !stall_i;
    for (int s = NSTG; s >= 1; s--) begin
      go[s] = !vld_q[s] || go[s+1];
    end
  end

  assign stall_o = !go[1];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (go[1]) begin
        vld_q[1] <= valid_i;
      end
      for (int s = 2; s <= NSTG; s++) begin
        if (go[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // inner product t = (0,v) * b
  qpu_qmul u_inner (
    .clk_i  (clk_i),
    .en_i   (go[3:1]),
    .p_i    (v_in),
    .q_i    (b_in),
    .r_o    (t_r),
    .clip_o (t_clip)
  );

  // outer product a * t, or a * b for the plain product
  assign q2_in = (cmd13_q[3] == CMD_SANDWICH) ? t_r : b13_q[3];

  qpu_qmul u_outer (
    .clk_i  (clk_i),
    .en_i   (go[6:4]),
    .p_i    (a13_q[3]),
    .q_i    (q2_in),
    .r_o    (u_r),
    .clip_o (u_clip)
  );

  // conjugate of a, negating the most negative word clips
  always_comb begin
    conj_d[0] = a13_q[3][0];
    csat_d    = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if (a13_q[3][i] == WORD_MIN) begin
        conj_d[i] = WORD_MAX;
        csat_d    = 1'b1;
      end else begin
        conj_d[i] = -a13_q[3][i];
      end
    end
  end

  // side data pipeline
  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      cmd13_q[1] <= cmd_e'(cmd_i);
      a13_q[1]   <= a_in;
      b13_q[1]   <= b_in;
    end
    for (int s = 2; s <= 3; s++) begin
      if (go[s]) begin
        cmd13_q[s] <= cmd13_q[s-1];
        a13_q[s]   <= a13_q[s-1];
        b13_q[s]   <= b13_q[s-1];
      end
    end
    if (go[4]) begin
      cmd46_q[4]  <= cmd13_q[3];
      conj46_q[4] <= conj_d;
      csat46_q[4] <= csat_d;
      tsat46_q[4] <= |t_clip;
    end
    for (int s = 5; s <= 6; s++) begin
      if (go[s]) begin
        cmd46_q[s]  <= cmd46_q[s-1];
        conj46_q[s] <= conj46_q[s-1];
        csat46_q[s] <= csat46_q[s-1];
        tsat46_q[s] <= tsat46_q[s-1];
      end
    end
  end

  // result select per operation
  always_comb begin
    unique case (cmd46_q[6])
      CMD_PRODUCT: begin
        r_d   = u_r;
        sat_d = |u_clip;
      end
      CMD_CONJ: begin
        r_d   = conj46_q[6];
        sat_d = csat46_q[6];
      end
      CMD_SANDWICH: begin
        r_d   = '{word_t'(0), u_r[1], u_r[2], u_r[3]};
        sat_d = tsat46_q[6] || (|u_clip[3:1]);
      end
      default: begin
        r_d   = '{default: word_t'(0)};
        sat_d = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (go[NSTG]) begin
      r_q   <= r_d;
      sat_q <= sat_d;
    end
  end

  assign valid_o     = vld_q[NSTG];
  assign r_w_o       = r_q[0];
  assign r_x_o       = r_q[1];
  assign r_y_o       = r_q[2];
  assign r_z_o       = r_q[3];
  assign saturated_o = sat_q;

  // a free output never holds back the input
  a_no_stall_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_i |-> !stall_o)
    else $error("input stalled while output is free");

  // a full pipe behind a stalled output stalls the input
  a_stall_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && stall_i) |-> stall_o)
    else $error("input taken into a full stalled pipe");

  // an accepted transfer lands in the first stage
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> vld_q[1])
    else $error("accepted transfer lost at first stage");

endmodule

[rtl/core/qpu_qmul.sv]
// ----------------------------------------------------------------------------
// qpu_qmul: pipelined fixed-point Hamilton product
// Three register stages: partial products, signed sums, truncate and saturate.
// Each stage loads on its own enable; validity is tracked by the caller.
// ----------------------------------------------------------------------------
module qpu_qmul
  import qpu_pkg::*;
(
  input  logic       clk_i,
  input  logic [2:0] en_i,
  input  quat_t      p_i,
  input  quat_t      q_i,
  output quat_t      r_o,
  output logic [3:0] clip_o
);

  prod_t prod_d [4][4];
  prod_t prod_q [4][4];
  acc_t  acc_d  [4];
  acc_t  acc_q  [4];
  quat_t r_d;
  quat_t r_q;
  logic [3:0] clip_d;
  logic [3:0] clip_q;

  // all sixteen component products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_d[i][j] = PROD_BITS'(p_i[i]) * PROD_BITS'(q_i[j]);
      end
    end
  end

  // signed sum of four terms per component
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc_d[k] = '0;
      for (int n = 0; n < 4; n++) begin
        if (hp_neg(2'(k), 2'(n))) begin
          acc_d[k] = acc_d[k] - ACC_BITS'(prod_q[n][k ^ n]);
        end else begin
          acc_d[k] = acc_d[k] + ACC_BITS'(prod_q[n][k ^ n]);
        end
      end
    end
  end

  // floor to the word's fraction, then clip to the word range
  always_comb begin
    sh_t sh;
    for (int k = 0; k < 4; k++) begin
      sh = SH_BITS'(acc_q[k] >>> FRAC_BITS);
      if ((&sh[SH_BITS-1:WORD_BITS-1]) || !(|sh[SH_BITS-1:WORD_BITS-1])) begin
        r_d[k]    = sh[WORD_BITS-1:0];
        clip_d[k] = 1'b0;
      end else begin
        r_d[k]    = sh[SH_BITS-1] ? WORD_MIN : WORD_MAX;
        clip_d[k] = 1'b1;
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
    end
    if (en_i[1]) begin
      acc_q <= acc_d;
    end
    if (en_i[2]) begin
      r_q    <= r_d;
      clip_q <= clip_d;
    end
  end

  assign r_o    = r_q;
  assign clip_o = clip_q;

endmodule

[sim/quaternion_product_unit_tb.sv]
// ----------------------------------------------------------------------------
// quaternion_product_unit_tb: self-checking bench of the quaternion unit
// Drives product, conjugate, sandwich and unused-opcode transfers: a directed
// set of corner cases first, then random operands under three sender/receiver
// idle mixes. Every result is predicted at full width, floored and clipped,
// and compared field by field in arrival order.
// ----------------------------------------------------------------------------
module quaternion_product_unit_tb;
  import qpu_pkg::*;

  localparam word_t       ONE         = word_t'(1 << FRAC_BITS);
  localparam word_t       NEG_ONE     = -ONE;
  // cos(45 deg) in Q4.28, for a quarter turn about z
  localparam word_t       COS45       = word_t'(189812531);
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    word_t w;
    word_t x;
    word_t y;
    word_t z;
  } quat_s;

  typedef struct packed {
    cmd_e  cmd;
    quat_s a;
    quat_s b;
    word_t v_x;
    word_t v_y;
    word_t v_z;
  } op_s;

  typedef struct packed {
    word_t w;
    word_t x;
    word_t y;
    word_t z;
    logic  sat;
  } result_s;

  // expected results of accepted transfers, in order
  class quat_checker;
    result_s     due_results[$];
    int unsigned mismatch_count;

    static function wide_t wmul(input word_t x, input word_t y);
      return wide_t'(x) * wide_t'(y);
    endfunction

    // floor to the word's fraction, then clip to the word range
    static function word_t trunc_sat(input wide_t s, output logic clipped);
      wide_t q;
      q = s >>> FRAC_BITS;
      clipped = 1'b1;
      if (q > wide_t'(WORD_MAX)) return WORD_MAX;
      if (q < wide_t'(WORD_MIN)) return WORD_MIN;
      clipped = 1'b0;
      return word_t'(q);
    endfunction

    // exact hamilton product p*q, one clip flag per component (bit 0 is w)
    static function void hamilton_mul(input quat_s p, input quat_s q,
                                      output quat_s r, output logic [3:0] clip);
      wide_t s0, s1, s2, s3;
      logic  c0, c1, c2, c3;
      s0 = wmul(p.w, q.w) - wmul(p.x, q.x) - wmul(p.y, q.y) - wmul(p.z, q.z);
      s1 = wmul(p.w, q.x) + wmul(p.x, q.w) + wmul(p.y, q.z) - wmul(p.z, q.y);
      s2 = wmul(p.w, q.y) - wmul(p.x, q.z) + wmul(p.y, q.w) + wmul(p.z, q.x);
      s3 = wmul(p.w, q.z) + wmul(p.x, q.y) - wmul(p.y, q.x) + wmul(p.z, q.w);
      r.w = trunc_sat(s0, c0);
      r.x = trunc_sat(s1, c1);
      r.y = trunc_sat(s2, c2);
      r.z = trunc_sat(s3, c3);
      clip = {c3, c2, c1, c0};
    endfunction

    static function result_s compute_quat_result(input op_s op);
      quat_s      t, r;
      logic [3:0] c_in, c_out;
      logic       cx, cy, cz;
      logic       sat;
      r   = '0;
      sat = 1'b0;
      case (op.cmd)
        CMD_PRODUCT: begin
          hamilton_mul(op.a, op.b, r, c_out);
          sat = |c_out;
        end
        // negation through the clip path: only the most negative word clips
        CMD_CONJ: begin
          r.w = op.a.w;
          r.x = trunc_sat((-wide_t'($signed(op.a.x))) <<< FRAC_BITS, cx);
          r.y = trunc_sat((-wide_t'($signed(op.a.y))) <<< FRAC_BITS, cy);
          r.z = trunc_sat((-wide_t'($signed(op.a.z))) <<< FRAC_BITS, cz);
          sat = cx | cy | cz;
        end
        // inner product clipped first; the dropped scalar never flags
        CMD_SANDWICH: begin
          hamilton_mul(quat_s'{'0, op.v_x, op.v_y, op.v_z}, op.b, t, c_in);
          hamilton_mul(op.a, t, r, c_out);
          r.w = '0;
          sat = (|c_in) | (|c_out[3:1]);
        end
        default: ;
      endcase
      return result_s'{r.w, r.x, r.y, r.z, sat};
    endfunction

    function void note_operands(input op_s op);
      due_results = {due_results, compute_quat_result(op)};
    endfunction

    function void check_field(input string name, input word_t want, input word_t got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(input result_s got);
      result_s want;
      if (due_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatch_count++;
        return;
      end
      want = due_results.pop_front();
      check_field("r_w", want.w, got.w);
      check_field("r_x", want.x, got.x);
      check_field("r_y", want.y, got.y);
      check_field("r_z", want.z, got.z);
      check_field("saturated", word_t'(want.sat), word_t'(got.sat));
    endfunction
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  cmd_i   = '0;
  word_t       a_w_i   = '0;
  word_t       a_x_i   = '0;
  word_t       a_y_i   = '0;
  word_t       a_z_i   = '0;
  word_t       b_w_i   = '0;
  word_t       b_x_i   = '0;
  word_t       b_y_i   = '0;
  word_t       b_z_i   = '0;
  word_t       v_x_i   = '0;
  word_t       v_y_i   = '0;
  word_t       v_z_i   = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  word_t       r_w_o;
  word_t       r_x_o;
  word_t       r_y_o;
  word_t       r_z_o;
  logic        saturated_o;

  quat_checker  checker_q;
  int unsigned  tx_idle_pct = 28;
  int unsigned  rx_idle_pct = 49;
  logic         hold_req    = 1'b0;
  int unsigned  hold_left   = 0;
  int unsigned  cycle_count = 0;

  quaternion_product_unit DUT (.*);

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (valid_o && !stall_i) begin
      checker_q.check_result(result_s'{r_w_o, r_x_o, r_y_o, r_z_o, saturated_o});
    end
    if (hold_left != 0) begin
      stall_i <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  function automatic word_t rand_word();
    case ($urandom_range(9))
      0, 1, 2, 3: return word_t'($urandom());
      // within about +-2.0
      4, 5, 6, 7: return word_t'($urandom_range(32'h4000_0000)) - word_t'(32'h2000_0000);
      8: begin
        case ($urandom_range(5))
          0:       return WORD_MIN;
          1:       return WORD_MAX;
          2:       return '0;
          3:       return word_t'(-1);
          4:       return ONE;
          default: return NEG_ONE;
        endcase
      end
      default: return word_t'($urandom_range(32)) - word_t'(16);
    endcase
  endfunction

  // offer one transfer after random idle cycles, return once accepted
  task automatic push_op(input op_s op);
    while ($urandom_range(99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    cmd_i   <= op.cmd;
    a_w_i   <= op.a.w;
    a_x_i   <= op.a.x;
    a_y_i   <= op.a.y;
    a_z_i   <= op.a.z;
    b_w_i   <= op.b.w;
    b_x_i   <= op.b.x;
    b_y_i   <= op.b.y;
    b_z_i   <= op.b.z;
    v_x_i   <= op.v_x;
    v_y_i   <= op.v_y;
    v_z_i   <= op.v_z;
    do @(posedge clk_i); while (stall_o);
    checker_q.note_operands(op);
  endtask

  // stop offering until every outstanding result has come back
  task automatic drain();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (checker_q.due_results.size() != 0);
  endtask

  task automatic run_random(input int unsigned count);
    op_s op;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(15))
        0, 1, 2, 3, 4, 5, 6:        op.cmd = CMD_PRODUCT;
        7, 8, 9, 10, 11, 12:        op.cmd = CMD_SANDWICH;
        13, 14:                     op.cmd = CMD_CONJ;
        default:                    op.cmd = CMD_NONE;
      endcase
      op.a   = quat_s'{rand_word(), rand_word(), rand_word(), rand_word()};
      op.b   = quat_s'{rand_word(), rand_word(), rand_word(), rand_word()};
      op.v_x = rand_word();
      op.v_y = rand_word();
      op.v_z = rand_word();
      push_op(op);
    end
  endtask

  initial begin
    quat_s qmin, qmax, qzero;
    checker_q = new();
    qmin  = quat_s'{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN};
    qmax  = quat_s'{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
    qzero = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners: products
    push_op(op_s'{CMD_PRODUCT, quat_s'{ONE, '0, '0, '0}, quat_s'{ONE, '0, '0, '0},
                  rand_word(), rand_word(), rand_word()});
    push_op(op_s'{CMD_PRODUCT, qmin, qmin, WORD_MIN, WORD_MIN, WORD_MIN});
    push_op(op_s'{CMD_PRODUCT, qmax, qmax, WORD_MAX, WORD_MAX, WORD_MAX});
    push_op(op_s'{CMD_PRODUCT, qmax, qmin, '0, '0, '0});
    push_op(op_s'{CMD_PRODUCT, qzero, qzero, rand_word(), rand_word(), rand_word()});
    // a one-lsb negative product floors to minus one lsb
    push_op(op_s'{CMD_PRODUCT, quat_s'{word_t'(-1), '0, '0, '0},
                  quat_s'{word_t'(1), '0, '0, '0}, '0, '0, '0});
    // i*j = k
    push_op(op_s'{CMD_PRODUCT, quat_s'{'0, ONE, '0, '0}, quat_s'{'0, '0, ONE, '0},
                  '0, '0, '0});

    // conjugate, including negation of the most negative word
    push_op(op_s'{CMD_CONJ, quat_s'{WORD_MAX, WORD_MIN, WORD_MAX, '0}, qmax,
                  rand_word(), rand_word(), rand_word()});
    push_op(op_s'{CMD_CONJ, qmin, qmin, WORD_MIN, WORD_MIN, WORD_MIN});
    push_op(op_s'{CMD_CONJ, quat_s'{word_t'(-1), word_t'(-1), word_t'(1), ONE}, qzero,
                  '0, '0, '0});

    // sandwich: identity, clipping inside, clipping only in the dropped scalar, extremes, a quarter turn
    push_op(op_s'{CMD_SANDWICH, quat_s'{ONE, '0, '0, '0}, quat_s'{ONE, '0, '0, '0},
                  ONE, NEG_ONE, WORD_MAX});
    push_op(op_s'{CMD_SANDWICH, qzero, qmax, WORD_MAX, WORD_MAX, WORD_MAX});
    push_op(op_s'{CMD_SANDWICH, quat_s'{'0, WORD_MAX, '0, '0}, quat_s'{ONE, '0, '0, '0},
                  WORD_MAX, '0, '0});
    push_op(op_s'{CMD_SANDWICH, qmin, qmin, WORD_MIN, WORD_MIN, WORD_MIN});
    push_op(op_s'{CMD_SANDWICH, quat_s'{COS45, '0, '0, COS45},
                  quat_s'{COS45, '0, '0, -COS45}, ONE, '0, '0});

    // unused opcode
    push_op(op_s'{CMD_NONE, qmax, qmin, WORD_MAX, WORD_MIN, WORD_MAX});
    push_op(op_s'{CMD_NONE, quat_s'{rand_word(), rand_word(), rand_word(), rand_word()},
                  quat_s'{rand_word(), rand_word(), rand_word(), rand_word()},
                  rand_word(), rand_word(), rand_word()});
    drain();

    // sender idles less than the receiver; one long receiver hold midway
    run_random(135);
    hold_req = 1'b1;
    run_random(135);
    drain();

    // receiver idles less than the sender
    tx_idle_pct = 49;
    rx_idle_pct = 28;
    run_random(270);
    drain();

    // no idling; the long hold fills the pipe while the sender keeps offering
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    run_random(260);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (checker_q.mismatch_count == 0 && checker_q.due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
